@@ rtl/nspd_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nspd_pkg
// Types, sizes and constant tables shared by the phase-shift demodulator.
// ----------------------------------------------------------------------------
package nspd_pkg;

  localparam int MAX_STEPS       = 8;
  localparam int PHASE_FRAC_BITS = 13;

  localparam int SAMPLE_W = 8;
  localparam int STEP_W   = 4;
  localparam int THR_W    = 8;
  localparam int MAC_IW   = $clog2(MAX_STEPS);

  // Sine and cosine sums, Q1.14 weights times 8-bit samples.
  localparam int SC_W = 27;

  localparam int CORDIC_STEPS = 24;
  localparam int CORDIC_IW    = $clog2(CORDIC_STEPS);
  localparam int CORDIC_W     = 36;
  localparam int ANGLE_W      = 32;

  // The partial root is kept scaled by the current trial bit, so it needs
  // the full width of the radicand until the last cell.
  localparam int SQ_W       = 52;
  localparam int ROOT_W     = SQ_W;
  localparam int SQRT_CELLS = 26;
  localparam int SQRT_IW    = $clog2(SQRT_CELLS);

  // The modulation is the root divided by N*8192.
  localparam int NORM_SHIFT = 13;
  localparam int DIV_CELLS  = 13;
  localparam int DIV_IW     = $clog2(DIV_CELLS);

  localparam logic [ANGLE_W-1:0] TWO_PI_Q329 = 32'd3373259426;
  localparam int RAD_SHIFT = 61 - PHASE_FRAC_BITS;
  localparam int PHASE_W   = 65 - RAD_SHIFT;
  localparam logic [64:0] TWO_PI_FULL =
    ((65'(TWO_PI_Q329) << 32) + (65'(1) << (RAD_SHIFT - 1))) >> RAD_SHIFT;
  localparam logic [PHASE_W-1:0] TWO_PI_Q = TWO_PI_FULL[PHASE_W-1:0];

  // The phase path is shorter than the magnitude path by this many stages.
  localparam int PH_DELAY = (2 + SQRT_CELLS + DIV_CELLS) - (CORDIC_STEPS + 3);
  localparam int PIPE     = MAX_STEPS + 2 + SQRT_CELLS + DIV_CELLS + 1;

  localparam logic REG_STEP_COUNT = 1'b0;
  localparam logic REG_THRESHOLD  = 1'b1;

  localparam logic [STEP_W-1:0] STEP_COUNT_RESET = 4'd4;
  localparam logic [THR_W-1:0]  THRESHOLD_RESET  = 8'd10;

  typedef struct packed {
    logic [SAMPLE_W-1:0] sample_0;
    logic [SAMPLE_W-1:0] sample_1;
    logic [SAMPLE_W-1:0] sample_2;
    logic [SAMPLE_W-1:0] sample_3;
    logic [SAMPLE_W-1:0] sample_4;
    logic [SAMPLE_W-1:0] sample_5;
    logic [SAMPLE_W-1:0] sample_6;
    logic [SAMPLE_W-1:0] sample_7;
  } pixel_t;

  typedef struct packed {
    logic [15:0] wrapped_phase;
    logic [7:0]  modulation;
    logic        modulation_ok;
  } result_t;

  typedef logic [MAX_STEPS-1:0][SAMPLE_W-1:0] sample_vec_t;

  // Rows are N = 3 .. 8.
  localparam logic signed [15:0] SIN_W [0:5][0:7] = '{
    '{16'sd0, 16'sd14189, -16'sd14189, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0},
    '{16'sd0, 16'sd16384, 16'sd0, -16'sd16384, 16'sd0, 16'sd0, 16'sd0, 16'sd0},
    '{16'sd0, 16'sd15582, 16'sd9630, -16'sd9630, -16'sd15582, 16'sd0, 16'sd0,
      16'sd0},
    '{16'sd0, 16'sd14189, 16'sd14189, 16'sd0, -16'sd14189, -16'sd14189, 16'sd0,
      16'sd0},
    '{16'sd0, 16'sd12810, 16'sd15973, 16'sd7109, -16'sd7109, -16'sd15973,
      -16'sd12810, 16'sd0},
    '{16'sd0, 16'sd11585, 16'sd16384, 16'sd11585, 16'sd0, -16'sd11585,
      -16'sd16384, -16'sd11585}
  };

  localparam logic signed [15:0] COS_W [0:5][0:7] = '{
    '{16'sd16384, -16'sd8192, -16'sd8192, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0},
    '{16'sd16384, 16'sd0, -16'sd16384, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0},
    '{16'sd16384, 16'sd5063, -16'sd13255, -16'sd13255, 16'sd5063, 16'sd0, 16'sd0,
      16'sd0},
    '{16'sd16384, 16'sd8192, -16'sd8192, -16'sd16384, -16'sd8192, 16'sd8192,
      16'sd0, 16'sd0},
    '{16'sd16384, 16'sd10215, -16'sd3646, -16'sd14761, -16'sd14761, -16'sd3646,
      16'sd10215, 16'sd0},
    '{16'sd16384, 16'sd11585, 16'sd0, -16'sd11585, -16'sd16384, -16'sd11585,
      16'sd0, 16'sd11585}
  };

  // atan(2^-k) as a fraction of a turn, scaled by 2^32.
  localparam logic [ANGLE_W-1:0] ATAN_TURNS [0:CORDIC_STEPS-1] = '{
    32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756, 32'd42667331,
    32'd21354465, 32'd10679838, 32'd5340245, 32'd2670163, 32'd1335087,
    32'd667544, 32'd333772, 32'd166886, 32'd83443, 32'd41722, 32'd20861,
    32'd10430, 32'd5215, 32'd2608, 32'd1304, 32'd652, 32'd326, 32'd163, 32'd81
  };

endpackage

@@ rtl/nspd_mac_cell.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nspd_mac_cell
// One step of the sine and cosine sums: adds one weighted sample.
// ----------------------------------------------------------------------------
module nspd_mac_cell (
  input  logic                              clk,
  input  logic [nspd_pkg::MAC_IW-1:0]       idx,
  input  logic [nspd_pkg::STEP_W-1:0]       n,
  input  nspd_pkg::sample_vec_t             x_in,
  input  logic signed [nspd_pkg::SC_W-1:0]  s_in,
  input  logic signed [nspd_pkg::SC_W-1:0]  c_in,
  output nspd_pkg::sample_vec_t             x_out,
  output logic signed [nspd_pkg::SC_W-1:0]  s_out,
  output logic signed [nspd_pkg::SC_W-1:0]  c_out
);
  import nspd_pkg::*;

  logic [2:0]         row;
  logic               used;
  logic signed [15:0] ws;
  logic signed [15:0] wc;
  logic signed [8:0]  xv;
  logic signed [24:0] ps;
  logic signed [24:0] pc;

  always_comb begin
    row  = 3'(n - STEP_W'(3));
    used = STEP_W'(idx) < n;
    ws   = used ? SIN_W[row][idx] : 16'sd0;
    wc   = used ? COS_W[row][idx] : 16'sd0;
    xv   = signed'({1'b0, x_in[idx]});
    ps   = xv * ws;
    pc   = xv * wc;
  end

  always_ff @(posedge clk) begin
    x_out <= x_in;
    s_out <= s_in + SC_W'(ps);
    c_out <= c_in + SC_W'(pc);
  end

endmodule

@@ rtl/nspd_cordic_cell.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nspd_cordic_cell
// One vectoring rotation that drives y toward zero and tracks the angle.
// ----------------------------------------------------------------------------
module nspd_cordic_cell (
  input  logic                                 clk,
  input  logic [nspd_pkg::CORDIC_IW-1:0]       k,
  input  logic signed [nspd_pkg::CORDIC_W-1:0] x_in,
  input  logic signed [nspd_pkg::CORDIC_W-1:0] y_in,
  input  logic [nspd_pkg::ANGLE_W-1:0]         a_in,
  output logic signed [nspd_pkg::CORDIC_W-1:0] x_out,
  output logic signed [nspd_pkg::CORDIC_W-1:0] y_out,
  output logic [nspd_pkg::ANGLE_W-1:0]         a_out
);
  import nspd_pkg::*;

  logic signed [CORDIC_W-1:0] xs;
  logic signed [CORDIC_W-1:0] ys;

  always_comb begin
    xs = x_in >>> k;
    ys = y_in >>> k;
  end

  always_ff @(posedge clk) begin
    if (!y_in[CORDIC_W-1]) begin
      x_out <= x_in + ys;
      y_out <= y_in - xs;
      a_out <= a_in + ATAN_TURNS[k];
    end else begin
      x_out <= x_in - ys;
      y_out <= y_in + xs;
      a_out <= a_in - ATAN_TURNS[k];
    end
  end

endmodule

@@ rtl/nspd_sqrt_cell.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nspd_sqrt_cell
// One digit of a restoring integer square root.
// ----------------------------------------------------------------------------
module nspd_sqrt_cell (
  input  logic                          clk,
  input  logic [nspd_pkg::SQRT_IW-1:0]  j,
  input  logic [nspd_pkg::SQ_W-1:0]     v_in,
  input  logic [nspd_pkg::ROOT_W-1:0]   r_in,
  output logic [nspd_pkg::SQ_W-1:0]     v_out,
  output logic [nspd_pkg::ROOT_W-1:0]   r_out
);
  import nspd_pkg::*;

  logic [5:0]      sh;
  logic [SQ_W-1:0] bitv;
  logic [SQ_W-1:0] trial;

  always_comb begin
    sh    = 6'(2 * (SQRT_CELLS - 1)) - {j, 1'b0};
    bitv  = SQ_W'(1) << sh;
    trial = SQ_W'(r_in) + bitv;
  end

  always_ff @(posedge clk) begin
    if (v_in >= trial) begin
      v_out <= v_in - trial;
      r_out <= (r_in >> 1) + bitv[ROOT_W-1:0];
    end else begin
      v_out <= v_in;
      r_out <= r_in >> 1;
    end
  end

endmodule

@@ rtl/nspd_div_cell.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nspd_div_cell
// One quotient bit of a restoring division by the step count.
// ----------------------------------------------------------------------------
module nspd_div_cell (
  input  logic                           clk,
  input  logic [nspd_pkg::DIV_IW-1:0]    b,
  input  logic [nspd_pkg::STEP_W-1:0]    n,
  input  logic [nspd_pkg::DIV_CELLS-1:0] dvd_in,
  input  logic [nspd_pkg::STEP_W-1:0]    rem_in,
  input  logic [nspd_pkg::DIV_CELLS-1:0] quo_in,
  output logic [nspd_pkg::DIV_CELLS-1:0] dvd_out,
  output logic [nspd_pkg::STEP_W-1:0]    rem_out,
  output logic [nspd_pkg::DIV_CELLS-1:0] quo_out
);
  import nspd_pkg::*;

  logic [DIV_IW-1:0] pos;
  logic [STEP_W:0]   r2;

  always_comb begin
    pos = DIV_IW'(DIV_CELLS - 1) - b;
    r2  = {rem_in, dvd_in[pos]};
  end

  always_ff @(posedge clk) begin
    dvd_out <= dvd_in;
    if (r2 >= {1'b0, n}) begin
      rem_out <= STEP_W'(r2 - {1'b0, n});
      quo_out <= {quo_in[DIV_CELLS-2:0], 1'b1};
    end else begin
      rem_out <= r2[STEP_W-1:0];
      quo_out <= {quo_in[DIV_CELLS-2:0], 1'b0};
    end
  end

endmodule

@@ rtl/n_step_phase_shift_demodulator.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// n_step_phase_shift_demodulator
// Wrapped phase and fringe modulation from N phase-shifted pixel samples.
// ----------------------------------------------------------------------------
// A pixel is taken on a rising edge with start high; busy is always low, so
// one pixel may be sent in every clock cycle. Each pixel gives one result,
// shown on result for a single cycle with done high. Results leave in the
// order pixels came in. The pipeline holds 8 multiply-accumulate cells for
// the sums, then in parallel 24 CORDIC cells for the angle and 26
// square-root cells plus 13 divider cells for the modulation; the angle is
// delayed to meet the modulation. The receiver cannot stall; a result not
// taken in its cycle is gone.
// The APB port holds step_count (address 0) and modulation_threshold
// (address 4); write them only while no pixel is in flight. Reset empties
// the pipeline, so no result comes out of it, and loads step_count = 4 and
// modulation_threshold = 10.
// ----------------------------------------------------------------------------
module n_step_phase_shift_demodulator (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  output logic              busy,
  input  nspd_pkg::pixel_t  pixel,
  output logic              done,
  output nspd_pkg::result_t result,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [2:0]        paddr,
  input  logic [31:0]       pwdata,
  output logic [31:0]       prdata,
  output logic              pready
);
  import nspd_pkg::*;

  logic [STEP_W-1:0] step_count;
  logic [THR_W-1:0]  modulation_threshold;
  logic [STEP_W-1:0] n;
  logic              accept;

  assign busy   = 1'b0;
  assign pready = 1'b1;
  assign accept = start && !busy;

  always_ff @(posedge clk) begin
    if (rst) begin
      step_count           <= STEP_COUNT_RESET;
      modulation_threshold <= THRESHOLD_RESET;
    end else if (psel && penable && pwrite) begin
      unique case (paddr[2])
        REG_STEP_COUNT: step_count           <= pwdata[STEP_W-1:0];
        REG_THRESHOLD:  modulation_threshold <= pwdata[THR_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[2])
      REG_STEP_COUNT: prdata = 32'(step_count);
      REG_THRESHOLD:  prdata = 32'(modulation_threshold);
      default:        prdata = '0;
    endcase
  end

  always_comb begin
    if (step_count < STEP_W'(3)) begin
      n = STEP_W'(3);
    end else if (step_count > STEP_W'(MAX_STEPS)) begin
      n = STEP_W'(MAX_STEPS);
    end else begin
      n = step_count;
    end
  end

  // Transfer tracking: one valid bit per pipeline stage.
  logic vld [0:PIPE-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < PIPE; i++) vld[i] <= 1'b0;
      done <= 1'b0;
    end else begin
      vld[0] <= accept;
      for (int i = 1; i < PIPE; i++) vld[i] <= vld[i-1];
      done <= vld[PIPE-1];
    end
  end

  // Sine and cosine sums.
  sample_vec_t             mx [0:MAX_STEPS];
  logic signed [SC_W-1:0]  ms [0:MAX_STEPS];
  logic signed [SC_W-1:0]  mc [0:MAX_STEPS];

  always_ff @(posedge clk) begin
    mx[0] <= {pixel.sample_7, pixel.sample_6, pixel.sample_5, pixel.sample_4,
              pixel.sample_3, pixel.sample_2, pixel.sample_1, pixel.sample_0};
  end
  assign ms[0] = '0;
  assign mc[0] = '0;

  for (genvar g = 0; g < MAX_STEPS; g++) begin : g_mac
    nspd_mac_cell u_mac (
      .clk   (clk),
      .idx   (MAC_IW'(g)),
      .n     (n),
      .x_in  (mx[g]),
      .s_in  (ms[g]),
      .c_in  (mc[g]),
      .x_out (mx[g+1]),
      .s_out (ms[g+1]),
      .c_out (mc[g+1])
    );
  end

  // Angle path: fold into the right half plane, then rotate.
  logic signed [CORDIC_W-1:0] cx [0:CORDIC_STEPS];
  logic signed [CORDIC_W-1:0] cy [0:CORDIC_STEPS];
  logic [ANGLE_W-1:0]         ca [0:CORDIC_STEPS];
  logic                       cz [0:CORDIC_STEPS];
  logic signed [CORDIC_W-1:0] px;
  logic signed [CORDIC_W-1:0] py;

  always_comb begin
    px = CORDIC_W'(mc[MAX_STEPS]) <<< 8;
    py = CORDIC_W'(ms[MAX_STEPS]) <<< 8;
  end

  always_ff @(posedge clk) begin
    cz[0] <= (ms[MAX_STEPS] == '0) && (mc[MAX_STEPS] == '0);
    if (mc[MAX_STEPS] < 0) begin
      cx[0] <= -px;
      cy[0] <= -py;
      ca[0] <= 32'h8000_0000;
    end else begin
      cx[0] <= px;
      cy[0] <= py;
      ca[0] <= '0;
    end
    for (int i = 1; i <= CORDIC_STEPS; i++) cz[i] <= cz[i-1];
  end

  for (genvar g = 0; g < CORDIC_STEPS; g++) begin : g_cordic
    nspd_cordic_cell u_cordic (
      .clk   (clk),
      .k     (CORDIC_IW'(g)),
      .x_in  (cx[g]),
      .y_in  (cy[g]),
      .a_in  (ca[g]),
      .x_out (cx[g+1]),
      .y_out (cy[g+1]),
      .a_out (ca[g+1])
    );
  end

  logic [63:0]        prod;
  logic               prod_zero;
  logic [64:0]        rsum;
  logic [PHASE_W-1:0] aq;
  logic [PHASE_W-1:0] aq_wrap;
  logic [PHASE_W-1:0] ph;
  logic [15:0]        ph_sat;
  logic [15:0]        phd [0:PH_DELAY-1];

  always_ff @(posedge clk) begin
    prod      <= ca[CORDIC_STEPS] * TWO_PI_Q329;
    prod_zero <= cz[CORDIC_STEPS];
  end

  always_comb begin
    rsum    = {1'b0, prod} + (65'(1) << (RAD_SHIFT - 1));
    aq      = rsum[64:RAD_SHIFT];
    aq_wrap = (aq >= TWO_PI_Q) ? aq - TWO_PI_Q : aq;
    ph_sat  = (ph > PHASE_W'(65535)) ? 16'hFFFF : 16'(ph);
  end

  always_ff @(posedge clk) begin
    ph     <= prod_zero ? TWO_PI_Q : TWO_PI_Q - aq_wrap;
    phd[0] <= ph_sat;
    for (int i = 1; i < PH_DELAY; i++) phd[i] <= phd[i-1];
  end

  // Magnitude path: squares, sum, root, then divide by N.
  logic signed [2*SC_W-1:0] s2;
  logic signed [2*SC_W-1:0] c2;
  logic [SQ_W-1:0]          sq_s;
  logic [SQ_W-1:0]          sq_c;
  logic [SQ_W-1:0]          sv [0:SQRT_CELLS];
  logic [ROOT_W-1:0]        rr [0:SQRT_CELLS];

  always_comb begin
    s2 = ms[MAX_STEPS] * ms[MAX_STEPS];
    c2 = mc[MAX_STEPS] * mc[MAX_STEPS];
  end

  always_ff @(posedge clk) begin
    sq_s  <= s2[SQ_W-1:0];
    sq_c  <= c2[SQ_W-1:0];
    sv[0] <= sq_s + sq_c;
  end
  assign rr[0] = '0;

  for (genvar g = 0; g < SQRT_CELLS; g++) begin : g_sqrt
    nspd_sqrt_cell u_sqrt (
      .clk   (clk),
      .j     (SQRT_IW'(g)),
      .v_in  (sv[g]),
      .r_in  (rr[g]),
      .v_out (sv[g+1]),
      .r_out (rr[g+1])
    );
  end

  logic [DIV_CELLS-1:0] dd [0:DIV_CELLS];
  logic [STEP_W-1:0]    dr [0:DIV_CELLS];
  logic [DIV_CELLS-1:0] dq [0:DIV_CELLS];

  assign dd[0] = rr[SQRT_CELLS][NORM_SHIFT+DIV_CELLS-1:NORM_SHIFT];
  assign dr[0] = '0;
  assign dq[0] = '0;

  for (genvar g = 0; g < DIV_CELLS; g++) begin : g_div
    nspd_div_cell u_div (
      .clk     (clk),
      .b       (DIV_IW'(g)),
      .n       (n),
      .dvd_in  (dd[g]),
      .rem_in  (dr[g]),
      .quo_in  (dq[g]),
      .dvd_out (dd[g+1]),
      .rem_out (dr[g+1]),
      .quo_out (dq[g+1])
    );
  end

  always_ff @(posedge clk) begin
    result.wrapped_phase <= phd[PH_DELAY-1];
    result.modulation    <= (dq[DIV_CELLS] > DIV_CELLS'(255)) ? 8'hFF
                                                              : dq[DIV_CELLS][7:0];
    result.modulation_ok <= dq[DIV_CELLS] > DIV_CELLS'(modulation_threshold);
  end

  a_latency: assert property (@(posedge clk) disable iff (rst)
    accept |-> ##(PIPE + 1) done)
    else $error("accepted pixel did not produce a result on time");

  a_phase_nonzero: assert property (@(posedge clk) disable iff (rst)
    done |-> (result.wrapped_phase != 16'd0))
    else $error("wrapped phase is zero");

  // A saturated modulation may sit at the threshold itself.
  a_flag_consistent: assert property (@(posedge clk) disable iff (rst)
    (done && result.modulation_ok) |->
      ((result.modulation > modulation_threshold) || (result.modulation == 8'hFF)))
    else $error("modulation flag set without modulation above threshold");

endmodule

@@ dv/n_step_phase_shift_demodulator_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// n_step_phase_shift_demodulator_checker
// Watches the pixel, result and APB channels of the demodulator. It predicts
// phase, modulation and flag for every pixel taken and compares each result
// with the oldest prediction in order.
// ----------------------------------------------------------------------------
module n_step_phase_shift_demodulator_checker (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  logic              busy,
  input  nspd_pkg::pixel_t  pixel,
  input  logic              done,
  input  nspd_pkg::result_t result,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [2:0]        paddr,
  input  logic [31:0]       pwdata,
  input  logic              pready,
  output int                fail_count,
  output int                pending
);
  import nspd_pkg::*;

  logic [STEP_W-1:0] steps_q;
  logic [THR_W-1:0]  thr_q;
  result_t           expected_results [$];

  // Angle of (c, s) as an unsigned fraction of a turn, by vectoring CORDIC.
  function automatic logic [31:0] turn_angle(input longint s, input longint c);
    longint x, y, xs, ys;
    logic [31:0] a;
    x = c * 256;
    y = s * 256;
    a = '0;
    if (x < 0) begin
      x = -x;
      y = -y;
      a = 32'h8000_0000;
    end
    for (int k = 0; k < CORDIC_STEPS; k++) begin
      xs = x >>> k;
      ys = y >>> k;
      if (y >= 0) begin
        x = x + ys;
        y = y - xs;
        a = a + ATAN_TURNS[k];
      end else begin
        x = x - ys;
        y = y + xs;
        a = a - ATAN_TURNS[k];
      end
    end
    return a;
  endfunction

  function automatic logic [63:0] int_root(input logic [63:0] v);
    logic [63:0] r, b;
    r = '0;
    b = 64'd1 << 62;
    while (b > v) b = b >> 2;
    while (b != 0) begin
      if (v >= r + b) begin
        v = v - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return r;
  endfunction

  function automatic result_t demodulate(input pixel_t p);
    sample_vec_t smp;
    int          n;
    longint      s, c;
    logic [63:0] full_turn, aq, phase, mag, md;
    result_t     r;
    smp = {p.sample_7, p.sample_6, p.sample_5, p.sample_4,
           p.sample_3, p.sample_2, p.sample_1, p.sample_0};
    n = steps_q;
    if (n < 3) n = 3;
    if (n > MAX_STEPS) n = MAX_STEPS;
    s = 0;
    c = 0;
    for (int i = 0; i < n; i++) begin
      s += longint'(smp[i]) * longint'(SIN_W[n-3][i]);
      c += longint'(smp[i]) * longint'(COS_W[n-3][i]);
    end
    full_turn = ((64'(TWO_PI_Q329) << 32) + (64'd1 << (RAD_SHIFT - 1))) >> RAD_SHIFT;
    if (s == 0 && c == 0) begin
      phase = full_turn;
    end else begin
      aq = (64'(turn_angle(s, c)) * 64'(TWO_PI_Q329) + (64'd1 << (RAD_SHIFT - 1)))
           >> RAD_SHIFT;
      if (aq >= full_turn) aq = aq - full_turn;
      phase = full_turn - aq;
    end
    if (phase > 64'hFFFF) phase = 64'hFFFF;
    mag = int_root(64'(s * s) + 64'(c * c));
    md = mag / (64'(n) * 64'd8192);
    r.wrapped_phase = phase[15:0];
    r.modulation    = (md > 255) ? 8'd255 : md[7:0];
    r.modulation_ok = (md > 64'(thr_q));
    return r;
  endfunction

  assign pending = expected_results.size();

  always @(posedge clk) begin
    if (rst) begin
      steps_q    <= STEP_COUNT_RESET;
      thr_q      <= THRESHOLD_RESET;
      fail_count <= 0;
      expected_results.delete();
    end else begin
      if (psel && penable && pwrite && pready) begin
        if (paddr == 3'(REG_STEP_COUNT) * 3'd4) steps_q <= pwdata[STEP_W-1:0];
        else if (paddr == 3'(REG_THRESHOLD) * 3'd4) thr_q <= pwdata[THR_W-1:0];
      end
      if (start && !busy) expected_results = {expected_results, demodulate(pixel)};
      if (done) begin
        if (expected_results.size() == 0) begin
          $display("%0t: unexpected result %h", $time, result);
          fail_count <= fail_count + 1;
        end else begin
          result_t e;
          e = expected_results.pop_front();
          if (e.wrapped_phase !== result.wrapped_phase ||
              e.modulation !== result.modulation ||
              e.modulation_ok !== result.modulation_ok) begin
            $display("%0t: expected phase %0d mod %0d ok %0b, got phase %0d mod %0d ok %0b",
                     $time, e.wrapped_phase, e.modulation, e.modulation_ok,
                     result.wrapped_phase, result.modulation, result.modulation_ok);
            fail_count <= fail_count + 1;
          end
        end
      end
    end
  end

endmodule

@@ dv/n_step_phase_shift_demodulator_tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// n_step_phase_shift_demodulator_tb
// Drives pixels and register writes into the demodulator across all step
// counts and a spread of thresholds, with random sender gaps, and takes the verdict from
// the checker.
// ----------------------------------------------------------------------------
module n_step_phase_shift_demodulator_tb;
  import nspd_pkg::*;

  localparam int LATENCY   = 51;
  localparam int MAX_CYCLE = 200000;

  logic        clk, rst, start, busy, done, psel, penable, pwrite, pready;
  pixel_t      pixel;
  result_t     result;
  logic [2:0]  paddr;
  logic [31:0] pwdata, prdata;
  int          fail_count, pending;
  int          cycle = 0;

  n_step_phase_shift_demodulator dut (.*);

  n_step_phase_shift_demodulator_checker checker_i (.*);

  initial begin
    clk = 0;
    forever #10 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle <= cycle + 1;
    if (cycle > MAX_CYCLE) begin
      $display("Some tests failed");
      $finish;
    end
  end

  task automatic reg_write(input logic addr_sel, input logic [31:0] value);
    @(posedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= 3'(addr_sel) * 3'd4;
    pwdata  <= value;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  // Sends one pixel; gap_pct is the percent chance of another idle cycle before it, tried again after each.
  task automatic send_pixel(input pixel_t p, input int gap_pct);
    while ($urandom_range(99) < gap_pct) begin
      start <= 1'b0;
      @(posedge clk);
    end
    start <= 1'b1;
    pixel <= p;
    @(posedge clk);
    while (busy) @(posedge clk);
  endtask

  task automatic drain();
    start <= 1'b0;
    while (pending != 0) @(posedge clk);
    repeat (LATENCY + 5) @(posedge clk);
  endtask

  function automatic pixel_t rand_pixel(input int style);
    pixel_t p;
    p = pixel_t'({$urandom, $urandom});
    // Near-flat pixels give small modulation and hit the threshold edge.
    if (style == 1) begin
      p.sample_1 = p.sample_0 ^ 8'($urandom_range(3));
      p.sample_2 = p.sample_0 ^ 8'($urandom_range(3));
      p.sample_3 = p.sample_0 ^ 8'($urandom_range(3));
      p.sample_4 = p.sample_0;
      p.sample_5 = p.sample_0 ^ 8'($urandom_range(7));
      p.sample_6 = p.sample_0;
      p.sample_7 = p.sample_0 ^ 8'($urandom_range(7));
    end
    return p;
  endfunction

  initial begin
    pixel_t p;
    int gap;
    rst = 1'b1; start = 1'b0; pixel = '0;
    psel = 1'b0; penable = 1'b0; pwrite = 1'b0; paddr = '0; pwdata = '0;
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    // Directed pixels at reset settings: zero vector, full scale, extremes.
    send_pixel('0, 0);
    send_pixel('1, 0);
    send_pixel({8'd255, 8'd0, 8'd255, 8'd0, 8'd255, 8'd0, 8'd255, 8'd0}, 0);
    send_pixel({8'd0, 8'd255, 8'd0, 8'd255, 8'd0, 8'd255, 8'd0, 8'd255}, 0);
    send_pixel({8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd255}, 0);
    send_pixel({8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd255, 8'd0, 8'd0}, 0);
    send_pixel({8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd255, 8'd0}, 0);
    drain();
    // Every step count, including out-of-range values, and threshold extremes.
    for (int sc = 0; sc < 16; sc++) begin
      reg_write(REG_STEP_COUNT, 32'(sc));
      reg_write(REG_THRESHOLD, (sc % 3 == 0) ? 32'd0 : (sc % 3 == 1) ? 32'd255 : 32'd10);
      send_pixel({8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd255}, 0);
      send_pixel(rand_pixel(0), 0);
      drain();
    end
    // Random phases over settings and sender idling profiles.
    for (int ph = 0; ph < 16; ph++) begin
      reg_write(REG_STEP_COUNT, (ph < 12) ? 32'($urandom_range(3, 8)) : 32'($urandom_range(15)));
      reg_write(REG_THRESHOLD, (ph % 4 == 0) ? 32'd0 : (ph % 4 == 1) ? 32'd255 :
                32'($urandom_range(40)));
      gap = (ph % 4 == 2) ? 73 : (ph % 4 == 3) ? 27 : 0;
      for (int i = 0; i < 55; i++) begin
        p = rand_pixel(($urandom_range(3) == 0) ? 1 : 0);
        send_pixel(p, gap);
      end
      drain();
    end
    if (fail_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
